/* hw/rtl/bba_pkg.sv */
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants of the block bitmap allocator
// Opcodes, sequencer states and default sizes of the free map.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  // default geometry of the free map
  localparam int unsigned NumBlocksDef = 2048;
  localparam int unsigned ReservedDef  = 3;
  localparam int unsigned WordBits     = 64;
  localparam int unsigned WordBitW     = 6;

  // request codes carried by an item
  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_TEST  = 2'd2
  } op_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_LOOKUP,
    ST_RESP
  } state_e;

endpackage

`default_nettype wire

/* hw/rtl/block_bitmap_allocator_top.sv */
// ----------------------------------------------------------------------------
// block_bitmap_allocator_top: next-fit block allocator over a free map
// Free map held in a word memory, scanned one word per cycle through a
// single masked priority encoder under a small sequencer.
// ----------------------------------------------------------------------------
//
// channel  | direction | handshake               | payload
// ---------+-----------+-------------------------+-----------------------------
// request  | in        | in_valid_i / in_stall_o | opcode_i, block_number_i
// response | out       | out_valid_o/out_stall_i | allocated_block_o, is_free_o,
//          |           |                         | request_ignored_o
//
// allocate scans from the search hint, wrapping once: one map word per
//   cycle through the priority encoder, then the write-back and reply
// free does one read-modify-write of a map word, test one read; an
//   ignored free, an out-of-range test or an unused opcode reads no word
// after reset the map memory is loaded one word per cycle, and until it is
//   loaded in_stall_o stays high
// one item at a time; the next item is taken while a reply still waits
// a stalled reply holds the sequencer in its reply state
//
`default_nettype none

module block_bitmap_allocator_top #(
  parameter int unsigned NUM_BLOCKS      = bba_pkg::NumBlocksDef,
  parameter int unsigned RESERVED_BLOCKS = bba_pkg::ReservedDef,
  localparam int unsigned BlkW           = $clog2(NUM_BLOCKS)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [1:0]      opcode_i,
  input  wire logic [BlkW-1:0] block_number_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [BlkW-1:0]      allocated_block_o,
  output logic                 is_free_o,
  output logic                 request_ignored_o
);

  localparam int unsigned WBits    = bba_pkg::WordBits;
  localparam int unsigned WBitW    = bba_pkg::WordBitW;
  localparam int unsigned MapWords = (NUM_BLOCKS + WBits - 1) / WBits;
  localparam int unsigned WA       = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int unsigned HW       = BlkW + 1;
  localparam int unsigned HWW      = HW - WBitW;
  localparam int unsigned TopBits  = NUM_BLOCKS % WBits;
  localparam logic [WBits-1:0] ResMask =
    (WBits'(1) << RESERVED_BLOCKS) - WBits'(1);
  localparam logic [WBits-1:0] TopMask =
    (TopBits == 0) ? '1 : ((WBits'(1) << TopBits) - WBits'(1));
  localparam logic [WA-1:0]  LastWord = WA'(MapWords - 1);

  // reset contents of one map word
  function automatic logic [WBits-1:0] reset_word(input logic [WA-1:0] w);
    logic [WBits-1:0] m;
    m = '1;
    if (w == '0) m = m & ~ResMask;
    if (w == LastWord) m = m & TopMask;
    return m;
  endfunction

  bba_pkg::state_e state_q, state_d;

  // map memory
  logic [WBits-1:0] map_mem [MapWords];
  logic [WBits-1:0] rd_data_q;
  logic             rd_en;
  logic [WA-1:0]    rd_addr;
  logic             wr_en;
  logic [WA-1:0]    wr_addr;
  logic [WBits-1:0] wr_data;

  // control state
  logic [HW-1:0]    hint_q, hint_d;
  logic [WA-1:0]    clr_ptr_q, clr_ptr_d;
  logic [WA-1:0]    ptr_q, ptr_d;
  logic             wrap_q, wrap_d;
  logic             first_q, first_d;
  logic             issue_q, issue_d;
  logic             vld_p_q, vld_p_d;
  logic             out_valid_q, out_valid_d;

  // payload state
  logic [WA-1:0]    addr_p_q, addr_p_d;
  logic [WBits-1:0] mask_p_q, mask_p_d;
  logic             last_p_q, last_p_d;
  logic             free_op_q, free_op_d;
  logic [BlkW-1:0]  blk_q, blk_d;
  logic [BlkW-1:0]  pend_blk_q, pend_blk_d;
  logic             pend_free_q, pend_free_d;
  logic             pend_ign_q, pend_ign_d;
  logic [BlkW-1:0]  res_blk_q, res_blk_d;
  logic             res_free_q, res_free_d;
  logic             res_ign_q, res_ign_d;

  // derived values
  logic [HWW-1:0]   hint_wd;
  logic [WBitW-1:0] hint_bit;
  logic             hint_hit;
  logic [WBits-1:0] lo_mask;
  logic [WBits-1:0] masked;
  logic             found;
  logic [WBitW-1:0] enc_idx;
  logic [HW-1:0]    found_blk;
  logic [HW-1:0]    in_blk_ext;
  logic [WBitW-1:0] blk_bit;
  logic             out_acc;

  assign hint_wd    = hint_q[HW-1:WBitW];
  assign hint_bit   = hint_q[WBitW-1:0];
  assign hint_hit   = HWW'(ptr_q) == hint_wd;
  assign lo_mask    = (WBits'(1) << hint_bit) - WBits'(1);
  assign in_blk_ext = HW'(block_number_i);
  assign blk_bit    = blk_q[WBitW-1:0];
  assign out_acc    = out_valid_q && !out_stall_i;

  // lowest free block in the word under evaluation
  assign masked = rd_data_q & mask_p_q;
  assign found  = |masked;
  always_comb begin
    enc_idx = '0;
    for (int i = WBits - 1; i >= 0; i--) begin
      if (masked[i]) enc_idx = WBitW'(i);
    end
  end
  assign found_blk = HW'({addr_p_q, enc_idx});

  // map memory with registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) map_mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_q <= map_mem[rd_addr];
  end

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bba_pkg::ST_CLEAR;
      hint_q      <= HW'(RESERVED_BLOCKS);
      clr_ptr_q   <= '0;
      ptr_q       <= '0;
      wrap_q      <= 1'b0;
      first_q     <= 1'b0;
      issue_q     <= 1'b0;
      vld_p_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hint_q      <= hint_d;
      clr_ptr_q   <= clr_ptr_d;
      ptr_q       <= ptr_d;
      wrap_q      <= wrap_d;
      first_q     <= first_d;
      issue_q     <= issue_d;
      vld_p_q     <= vld_p_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    addr_p_q    <= addr_p_d;
    mask_p_q    <= mask_p_d;
    last_p_q    <= last_p_d;
    free_op_q   <= free_op_d;
    blk_q       <= blk_d;
    pend_blk_q  <= pend_blk_d;
    pend_free_q <= pend_free_d;
    pend_ign_q  <= pend_ign_d;
    res_blk_q   <= res_blk_d;
    res_free_q  <= res_free_d;
    res_ign_q   <= res_ign_d;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    hint_d      = hint_q;
    clr_ptr_d   = clr_ptr_q;
    ptr_d       = ptr_q;
    wrap_d      = wrap_q;
    first_d     = first_q;
    issue_d     = issue_q;
    vld_p_d     = 1'b0;
    out_valid_d = out_valid_q && !out_acc;
    addr_p_d    = addr_p_q;
    mask_p_d    = mask_p_q;
    last_p_d    = last_p_q;
    free_op_d   = free_op_q;
    blk_d       = blk_q;
    pend_blk_d  = pend_blk_q;
    pend_free_d = pend_free_q;
    pend_ign_d  = pend_ign_q;
    res_blk_d   = res_blk_q;
    res_free_d  = res_free_q;
    res_ign_d   = res_ign_q;
    in_stall_o  = 1'b1;
    rd_en       = 1'b0;
    rd_addr     = ptr_q;
    wr_en       = 1'b0;
    wr_addr     = addr_p_q;
    wr_data     = '0;

    case (state_q)
      // load the reset map, one word a cycle
      bba_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_ptr_q;
        wr_data = reset_word(clr_ptr_q);
        clr_ptr_d = clr_ptr_q + WA'(1);
        if (clr_ptr_q == LastWord) state_d = bba_pkg::ST_IDLE;
      end

      // take an item and start its work
      bba_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        rd_addr    = WA'(block_number_i >> WBitW);
        if (in_valid_i) begin
          blk_d       = block_number_i;
          pend_blk_d  = '0;
          pend_free_d = 1'b0;
          pend_ign_d  = 1'b0;
          free_op_d   = 1'b0;
          case (bba_pkg::op_e'(opcode_i))
            bba_pkg::OP_ALLOC: begin
              first_d = 1'b1;
              issue_d = 1'b1;
              if (hint_wd >= HWW'(MapWords)) begin
                ptr_d  = '0;
                wrap_d = 1'b1;
              end else begin
                ptr_d  = WA'(hint_wd);
                wrap_d = 1'b0;
              end
              state_d = bba_pkg::ST_SCAN;
            end
            bba_pkg::OP_FREE: begin
              if (in_blk_ext < HW'(RESERVED_BLOCKS) || in_blk_ext >= HW'(NUM_BLOCKS)) begin
                pend_ign_d = 1'b1;
                state_d    = bba_pkg::ST_RESP;
              end else begin
                rd_en     = 1'b1;
                free_op_d = 1'b1;
                state_d   = bba_pkg::ST_LOOKUP;
              end
            end
            bba_pkg::OP_TEST: begin
              if (in_blk_ext >= HW'(NUM_BLOCKS)) begin
                state_d = bba_pkg::ST_RESP;
              end else begin
                rd_en   = 1'b1;
                state_d = bba_pkg::ST_LOOKUP;
              end
            end
            default: begin
              state_d = bba_pkg::ST_RESP;
            end
          endcase
        end
      end

      // issue one word read a cycle, evaluate the word read the cycle before
      bba_pkg::ST_SCAN: begin
        if (issue_q) begin
          rd_en    = 1'b1;
          rd_addr  = ptr_q;
          addr_p_d = ptr_q;
          vld_p_d  = 1'b1;
          if (first_q && !wrap_q) mask_p_d = ~lo_mask;
          else if (wrap_q && hint_hit) mask_p_d = lo_mask;
          else mask_p_d = '1;
          last_p_d = wrap_q && (hint_hit || ptr_q == LastWord);
          first_d  = 1'b0;
          if (ptr_q == LastWord) begin
            ptr_d  = '0;
            wrap_d = 1'b1;
          end else begin
            ptr_d = ptr_q + WA'(1);
          end
          if (last_p_d) issue_d = 1'b0;
        end
        if (vld_p_q) begin
          if (found) begin
            wr_en      = 1'b1;
            wr_addr    = addr_p_q;
            wr_data    = rd_data_q & ~(WBits'(1) << enc_idx);
            hint_d     = found_blk + HW'(1);
            pend_blk_d = BlkW'(found_blk);
            issue_d    = 1'b0;
            vld_p_d    = 1'b0;
            state_d    = bba_pkg::ST_RESP;
          end else if (last_p_q) begin
            issue_d = 1'b0;
            vld_p_d = 1'b0;
            state_d = bba_pkg::ST_RESP;
          end
        end
      end

      // read-modify-write for free, bit report for test
      bba_pkg::ST_LOOKUP: begin
        if (free_op_q) begin
          wr_en   = 1'b1;
          wr_addr = WA'(blk_q >> WBitW);
          wr_data = rd_data_q | (WBits'(1) << blk_bit);
          if (HW'(blk_q) < hint_q) hint_d = HW'(blk_q);
        end else begin
          pend_free_d = rd_data_q[blk_bit];
        end
        state_d = bba_pkg::ST_RESP;
      end

      // hand the reply to the output register
      bba_pkg::ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          res_blk_d   = pend_blk_q;
          res_free_d  = pend_free_q;
          res_ign_d   = pend_ign_q;
          state_d     = bba_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = bba_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign allocated_block_o = res_blk_q;
  assign is_free_o         = res_free_q;
  assign request_ignored_o = res_ign_q;

  // hint stays between the first usable block and the end of the map
  a_hint_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hint_q >= HW'(RESERVED_BLOCKS) && hint_q <= HW'(NUM_BLOCKS))
    else $error("search hint out of range");

  // a granted block is never a reserved one
  a_grant_not_reserved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (allocated_block_o == '0 ||
                     HW'(allocated_block_o) >= HW'(RESERVED_BLOCKS)))
    else $error("reserved block granted");

  // at most one kind of answer per reply
  a_reply_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_free_o && request_ignored_o) &&
                    !(allocated_block_o != '0 && (is_free_o || request_ignored_o)))
    else $error("reply carries conflicting fields");

  // scan words in flight only while scanning
  a_scan_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_p_q || issue_q) |-> state_q == bba_pkg::ST_SCAN)
    else $error("scan activity outside scan state");

  // a grant always advances the hint just past the granted block
  a_hint_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bba_pkg::ST_SCAN && vld_p_q && found) |=>
      hint_q == $past(found_blk) + HW'(1))
    else $error("hint not moved past granted block");

endmodule

`default_nettype wire
